### sv/mwus_pkg.sv
// Package for the max-weight unit job scheduler.
// Holds sizes, request kinds and entry type; no dependencies.
package mwus_pkg;
  localparam int HEAP_DEPTH  = 1024;
  localparam int WEIGHT_BITS = 20;
  localparam int SLOT_BITS   = 16;
  localparam int ADDR_BITS   = $clog2(HEAP_DEPTH);
  localparam int COUNT_BITS  = $clog2(HEAP_DEPTH + 1);
  localparam int ENTRY_BITS  = WEIGHT_BITS + SLOT_BITS;
  localparam int PEN_BITS    = 48;

  typedef enum logic [1:0] {
    KIND_ARRIVE = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight;
    logic [SLOT_BITS-1:0]   slots;
  } entry_t;
endpackage

### sv/max_weight_unit_job_scheduler_unit.sv
// Top level of the max-weight unit job scheduler.
// Uses mwus_pkg, mwus_ram (heap store) and mwus_mac (penalty sum).
//
// Requests enter on start/kind/job_weight/job_slots at an edge where busy is
// low; each request yields exactly one result, shown for one cycle with
// strobe high. The receiver cannot stall; results are simply presented.
// The heap lives in one RAM of weight and slot pairs, with a registered read.
// Steps from the accepting edge to the edge that raises strobe:
//   straight from idle for a zero-slot arrive, a full-heap drop, an arrive into
//   an empty heap, a tick or finish on an empty heap and the unused kind;
//   arrive: a read and a compare state per level compared on the climb, plus
//   a state that writes the root when the job reaches the root;
//   tick: a read and a check of the root, done when the served job stays or
//   empties the heap, else a read of the tail, then a left read, right read and
//   compare per level on the sift-down, plus a write when it lands on a leaf;
//   finish: one RAM read per entry, then drain states that empty the
//   multiply-accumulate.
// One request is in flight at a time; busy is low in the result cycle, so
// the next request may be accepted at the edge that ends it. Reset empties
// the heap by clearing the entry count; the RAM is not cleared.
module max_weight_unit_job_scheduler_unit import mwus_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [1:0]             kind,
  input  logic [WEIGHT_BITS-1:0] job_weight,
  input  logic [SLOT_BITS-1:0]   job_slots,
  output logic                   busy,
  output logic                   strobe,
  output logic                   served,
  output logic [WEIGHT_BITS-1:0] served_weight,
  output logic [PEN_BITS-1:0]    total_penalty,
  output logic                   dropped,
  output logic                   done_res
);
  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_UP_TOP, S_TK_RD, S_TK_CHK, S_LAST_RD, S_LAST_GET,
    S_DN_L, S_DN_R, S_DN_CMP, S_DN_PUT, S_FIN, S_FIN_W1, S_FIN_W2, S_FIN_W3
  } state_t;

  state_t state;
  logic [COUNT_BITS-1:0]  count;
  logic [ADDR_BITS-1:0]   pos, raddr, waddr, par_pos, gpar_pos, nxt_pos;
  entry_t                 cur, lft, wdata, rdata;
  logic                   we, mac_clr, mac_en, r_ok, left_big, right_big;
  logic [WEIGHT_BITS-1:0] big_weight;
  logic [PEN_BITS-1:0]    mac_total;
  logic [COUNT_BITS:0]    lidx, ridx, nlidx;

  mwus_ram #(.WIDTH(ENTRY_BITS), .DEPTH(HEAP_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  mwus_mac u_mac (.clk(clk), .clr(mac_clr), .en(mac_en), .term(rdata),
                  .total(mac_total));

  assign par_pos    = (pos - ADDR_BITS'(1)) >> 1;
  assign gpar_pos   = (par_pos - ADDR_BITS'(1)) >> 1;
  assign lidx       = {1'b0, pos, 1'b1};
  assign ridx       = lidx + (COUNT_BITS+1)'(1);
  assign r_ok       = ridx < {1'b0, count};
  assign left_big   = lft.weight > cur.weight;
  assign big_weight = left_big ? lft.weight : cur.weight;
  assign right_big  = r_ok && (rdata.weight > big_weight);
  assign nxt_pos    = right_big ? ridx[ADDR_BITS-1:0] : lidx[ADDR_BITS-1:0];
  assign nlidx      = {1'b0, nxt_pos, 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      busy          <= 1'b0;
      strobe        <= 1'b0;
      we            <= 1'b0;
      mac_clr       <= 1'b1;
      mac_en        <= 1'b0;
      served        <= 1'b0;
      served_weight <= '0;
      total_penalty <= '0;
      dropped       <= 1'b0;
      done_res      <= 1'b0;
    end else begin
      strobe  <= 1'b0;
      we      <= 1'b0;
      mac_clr <= 1'b0;
      mac_en  <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          served <= 1'b0; served_weight <= '0; total_penalty <= '0;
          dropped <= 1'b0; done_res <= 1'b0;
          unique case (kind_t'(kind))
            KIND_ARRIVE: begin
              if (job_slots == '0) begin
                strobe <= 1'b1;
              end else if (count == COUNT_BITS'(HEAP_DEPTH)) begin
                dropped <= 1'b1; strobe <= 1'b1;
              end else if (count == '0) begin
                we <= 1'b1; waddr <= '0;
                wdata <= '{weight: job_weight, slots: job_slots};
                count <= COUNT_BITS'(1);
                strobe <= 1'b1;
              end else begin
                // hold the new job aside and climb from the tail
                cur <= '{weight: job_weight, slots: job_slots};
                pos <= count[ADDR_BITS-1:0];
                raddr <= (count[ADDR_BITS-1:0] - ADDR_BITS'(1)) >> 1;
                count <= count + COUNT_BITS'(1);
                busy <= 1'b1;
                state <= S_UP_RD;
              end
            end
            KIND_TICK: begin
              if (count == '0) strobe <= 1'b1;
              else begin
                raddr <= '0; busy <= 1'b1; state <= S_TK_RD;
              end
            end
            KIND_FINISH: begin
              done_res <= 1'b1;
              if (count == '0) strobe <= 1'b1;
              else begin
                mac_clr <= 1'b1; busy <= 1'b1;
                pos <= '0; raddr <= '0; state <= S_FIN;
              end
            end
            KIND_NONE: strobe <= 1'b1;
          endcase
        end
        S_UP_RD: state <= S_UP_CMP;
        S_UP_CMP: begin
          if (rdata.weight >= cur.weight) begin
            we <= 1'b1; waddr <= pos; wdata <= cur;
            busy <= 1'b0; strobe <= 1'b1; state <= S_IDLE;
          end else begin
            // pull the parent down into the hole
            we <= 1'b1; waddr <= pos; wdata <= rdata;
            pos <= par_pos;
            if (par_pos == '0) begin
              state <= S_UP_TOP;
            end else begin
              raddr <= gpar_pos; state <= S_UP_RD;
            end
          end
        end
        S_UP_TOP: begin
          we <= 1'b1; waddr <= '0; wdata <= cur;
          busy <= 1'b0; strobe <= 1'b1; state <= S_IDLE;
        end
        S_TK_RD: state <= S_TK_CHK;
        S_TK_CHK: begin
          served <= 1'b1; served_weight <= rdata.weight;
          if (rdata.slots != SLOT_BITS'(1)) begin
            we <= 1'b1; waddr <= '0;
            wdata <= '{weight: rdata.weight, slots: rdata.slots - SLOT_BITS'(1)};
            busy <= 1'b0; strobe <= 1'b1; state <= S_IDLE;
          end else if (count == COUNT_BITS'(1)) begin
            count <= '0;
            busy <= 1'b0; strobe <= 1'b1; state <= S_IDLE;
          end else begin
            count <= count - COUNT_BITS'(1);
            raddr <= ADDR_BITS'(count - COUNT_BITS'(1));
            state <= S_LAST_RD;
          end
        end
        S_LAST_RD: state <= S_LAST_GET;
        S_LAST_GET: begin
          // sink the former tail from the root
          cur <= rdata; pos <= '0;
          if (count > COUNT_BITS'(1)) begin
            raddr <= ADDR_BITS'(1); state <= S_DN_L;
          end else begin
            we <= 1'b1; waddr <= '0; wdata <= rdata;
            busy <= 1'b0; strobe <= 1'b1; state <= S_IDLE;
          end
        end
        S_DN_L: begin
          raddr <= ridx[ADDR_BITS-1:0]; state <= S_DN_R;
        end
        S_DN_R: begin
          lft <= rdata; state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (left_big || right_big) begin
            // lift the heavier child into the hole
            we <= 1'b1; waddr <= pos; wdata <= right_big ? rdata : lft;
            pos <= nxt_pos;
            if (nlidx < {1'b0, count}) begin
              raddr <= nlidx[ADDR_BITS-1:0]; state <= S_DN_L;
            end else begin
              state <= S_DN_PUT;
            end
          end else begin
            we <= 1'b1; waddr <= pos; wdata <= cur;
            busy <= 1'b0; strobe <= 1'b1; state <= S_IDLE;
          end
        end
        S_DN_PUT: begin
          we <= 1'b1; waddr <= pos; wdata <= cur;
          busy <= 1'b0; strobe <= 1'b1; state <= S_IDLE;
        end
        S_FIN: begin
          // one read per entry; the registered read data feeds the MAC
          mac_en <= 1'b1;
          if (COUNT_BITS'(pos) + COUNT_BITS'(1) < count) begin
            raddr <= pos + ADDR_BITS'(1); pos <= pos + ADDR_BITS'(1);
          end else begin
            state <= S_FIN_W1;
          end
        end
        S_FIN_W1: state <= S_FIN_W2;
        S_FIN_W2: state <= S_FIN_W3;
        S_FIN_W3: begin
          total_penalty <= mac_total; count <= '0;
          busy <= 1'b0; strobe <= 1'b1; state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

### sv/mwus_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module mwus_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/mwus_mac.sv
// Saturating multiply-accumulate for the penalty total, one term per cycle.
// Uses mwus_pkg.
module mwus_mac import mwus_pkg::*; (
  input  logic                   clk,
  input  logic                   clr,
  input  logic                   en,
  input  entry_t                 term,
  output logic [PEN_BITS-1:0]    total
);
  localparam logic [PEN_BITS-1:0] PEN_MAX = {PEN_BITS{1'b1}};
  logic [ENTRY_BITS-1:0] prod;
  logic                  prod_vld;
  logic [PEN_BITS:0]     sum;

  assign sum = {1'b0, total} + (PEN_BITS+1)'(prod);

  always_ff @(posedge clk) begin
    prod <= ENTRY_BITS'(term.weight) * ENTRY_BITS'(term.slots);
    if (clr) begin
      prod_vld <= 1'b0;
      total    <= '0;
    end else begin
      prod_vld <= en;
      if (prod_vld) total <= sum[PEN_BITS] ? PEN_MAX : sum[PEN_BITS-1:0];
    end
  end
endmodule
